[design/text_console_glyph_renderer_defines.svh]
// ----------------------------------------------------------------------------
// Text console glyph renderer assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TCGR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcgr: same-cycle property violated");

// Next-cycle implication, sampled on clk, off during rst.
`define TCGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcgr: next-cycle property violated");

`endif

[design/tcgr_pkg.sv]
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared constants, transaction types and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcgr_pkg;

  localparam int MAX_CHAR_WIDTH   = 32;
  localparam int MAX_CHAR_HEIGHT  = 64;
  localparam int MAX_TEXT_COLUMNS = 1023;
  localparam int MAX_TEXT_ROWS    = 511;
  localparam int MAX_LINE_PITCH   = 8192;
  localparam int ROW_LIMIT        = 1023;

  localparam int CW_W    = 6;
  localparam int CH_W    = 7;
  localparam int COLS_W  = 10;
  localparam int ROWS_W  = 9;
  localparam int PITCH_W = 14;
  localparam int COLOR_W = 24;
  localparam int ADDR_W  = 26;
  localparam int LINES_W = 15;

  localparam int COL_W = 10;
  localparam int ROW_W = 10;
  localparam int GBC_W = 2;
  localparam int GPR_W = 6;

  localparam int X_W    = 16;
  localparam int Y_W    = 16;
  localparam int YOFF_W = Y_W + PITCH_W;
  localparam int PIX_N  = 8;

  localparam int DIV_N_W = COL_W + 1;
  localparam int DIV_D_W = COLS_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT  = 3'd7;

  localparam logic [1:0] KIND_GLYPH = 2'd0;
  localparam logic [1:0] KIND_CR    = 2'd1;
  localparam logic [1:0] KIND_LF    = 2'd2;

  localparam logic RK_PIXEL  = 1'b0;
  localparam logic RK_SCROLL = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] glyph_byte;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic [LINES_W-1:0] scroll_lines;
    logic               last;
  } result_t;

  typedef struct packed {
    logic load;
    logic check;
    logic mul1;
    logic mul2;
    logic emit_scroll;
    logic emit_pixel;
    logic advance;
    logic div_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic item_glyph;
    logic scroll_pend;
    logic any_pixel;
    logic pix_last;
    logic out_free;
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage

[design/text_console_glyph_renderer.sv]
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Takes glyph bitmap bytes (byte column, then pixel row), carriage returns and
// line feeds, and turns each glyph byte into up to eight framebuffer pixel
// writes, preceded by a scroll request when a glyph starts below the last text
// row. The last result of each transaction carries last. Carriage return, line
// feed and the unused kind are taken in the idle state. A glyph byte passes
// through the scroll check and two multiply stages, then the scroll request if
// any and a pixel loop with one result per pixel written, then the cursor
// advance; each result holds the output register until it is taken, so a
// stalled consumer stalls the loop. When the final byte of a glyph pushes the
// cursor a full text row or more past the end, the bit-serial column divider
// runs before the next item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_glyph_renderer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  tcgr_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output tcgr_pkg::result_t              result
);
  import tcgr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tcgr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  tcgr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[design/tcgr_div.sv]
// ----------------------------------------------------------------------------
// Text console glyph renderer column divider
// Restoring divider, one quotient bit per cycle, for multi-row column wrap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcgr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tcgr_pkg::DIV_N_W-1:0] dividend,
  input  logic [tcgr_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [tcgr_pkg::DIV_N_W-1:0] quotient,
  output logic [tcgr_pkg::DIV_D_W-1:0] remainder
);
  import tcgr_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [DIV_N_W-1:0]   quot;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W+1:0]   trial;
  logic                 ge;

  assign shifted = {rem, quot[DIV_N_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};
  assign ge      = ~trial[DIV_D_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_N_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[DIV_N_W-2:0], ge};
      rem  <= ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
    end
  end

  assign quotient  = quot;
  assign remainder = rem;

endmodule

[design/tcgr_dp.sv]
// ----------------------------------------------------------------------------
// Text console glyph renderer datapath
// Register file, cursor state, address arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcgr_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  tcgr_pkg::item_t                item,
  input  tcgr_pkg::dp_cmd_t              cmd,
  output tcgr_pkg::dp_status_t           status,
  output logic                           result_valid,
  input  logic                           result_ready,
  output tcgr_pkg::result_t              result
);
  import tcgr_pkg::*;

  // configuration registers
  logic [CW_W-1:0]    char_width;
  logic [CH_W-1:0]    char_height;
  logic [COLS_W-1:0]  text_columns;
  logic [ROWS_W-1:0]  text_rows;
  logic [PITCH_W-1:0] line_pitch;
  logic [COLOR_W-1:0] text_color;
  logic [COLOR_W-1:0] background_color;
  logic               transparent_background;

  // effective values
  logic [CW_W-1:0]    cw;
  logic [CH_W-1:0]    ch;
  logic [COLS_W-1:0]  cols;
  logic [ROWS_W-1:0]  rows;
  logic [PITCH_W-1:0] pitch;

  // cursor state
  logic [COL_W-1:0] cursor_column;
  logic [ROW_W-1:0] cursor_row;
  logic [GBC_W-1:0] glyph_byte_column;
  logic [GPR_W-1:0] glyph_pixel_row;

  // per-transaction working registers
  logic [7:0]         bits;
  logic [ROW_W-1:0]   excess;
  logic               scroll_pend;
  logic [X_W-1:0]     xbase;
  logic [Y_W-1:0]     ybase;
  logic [X_W-1:0]     area_w;
  logic [Y_W-1:0]     area_h;
  logic [LINES_W-1:0] lines;
  logic [YOFF_W-1:0]  yoff;
  logic [PIX_N-1:0]   mask;
  logic [PIX_N-1:0]   mask_next;

  logic [ROW_W-1:0]   row_inc1;
  logic               chk_start;
  logic               col_over;
  logic [ROW_W-1:0]   row_a;
  logic [ROW_W-1:0]   exc_raw;

  logic [GPR_W:0]     gpr1;
  logic [GBC_W:0]     gbc1;
  logic [CW_W:0]      bpr_sum;
  logic [CW_W-3:0]    bpr;
  logic [COL_W:0]     next_col;
  logic [COL_W:0]     wrap_diff;
  logic               row_done;
  logic               glyph_done;
  logic               col_wrap;
  logic               need_div;

  logic [2:0]         sel_k;
  logic [PIX_N-1:0]   mask_cleared;
  logic               pix_last;

  logic               div_done;
  logic [DIV_N_W-1:0] div_q;
  logic [DIV_D_W-1:0] div_r;
  logic [ROW_W+1:0]   row_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_width             <= CW_W'(8);
      char_height            <= CH_W'(16);
      text_columns           <= COLS_W'(80);
      text_rows              <= ROWS_W'(25);
      line_pitch             <= PITCH_W'(1024);
      text_color             <= COLOR_W'(24'hCCCCCC);
      background_color       <= '0;
      transparent_background <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CHAR_WIDTH:   char_width             <= cfg_data[CW_W-1:0];
        CFG_CHAR_HEIGHT:  char_height            <= cfg_data[CH_W-1:0];
        CFG_TEXT_COLUMNS: text_columns           <= cfg_data[COLS_W-1:0];
        CFG_TEXT_ROWS:    text_rows              <= cfg_data[ROWS_W-1:0];
        CFG_LINE_PITCH:   line_pitch             <= cfg_data[PITCH_W-1:0];
        CFG_TEXT_COLOR:   text_color             <= cfg_data[COLOR_W-1:0];
        CFG_BG_COLOR:     background_color       <= cfg_data[COLOR_W-1:0];
        CFG_TRANSPARENT:  transparent_background <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cw    = (char_width == '0) ? CW_W'(1) :
                 (char_width > CW_W'(MAX_CHAR_WIDTH)) ? CW_W'(MAX_CHAR_WIDTH) : char_width;
  assign ch    = (char_height == '0) ? CH_W'(1) :
                 (char_height > CH_W'(MAX_CHAR_HEIGHT)) ? CH_W'(MAX_CHAR_HEIGHT) : char_height;
  assign cols  = (text_columns == '0) ? COLS_W'(1) :
                 (text_columns > COLS_W'(MAX_TEXT_COLUMNS)) ? COLS_W'(MAX_TEXT_COLUMNS) :
                 text_columns;
  assign rows  = (text_rows == '0) ? ROWS_W'(1) :
                 (text_rows > ROWS_W'(MAX_TEXT_ROWS)) ? ROWS_W'(MAX_TEXT_ROWS) : text_rows;
  assign pitch = (line_pitch == '0) ? PITCH_W'(1) :
                 (line_pitch > PITCH_W'(MAX_LINE_PITCH)) ? PITCH_W'(MAX_LINE_PITCH) :
                 line_pitch;

  // scroll check at glyph start
  assign row_inc1  = (cursor_row == ROW_W'(ROW_LIMIT)) ? cursor_row : cursor_row + ROW_W'(1);
  assign chk_start = (glyph_byte_column == '0) && (glyph_pixel_row == '0);
  assign col_over  = cursor_column >= COL_W'(cols);
  assign row_a     = col_over ? row_inc1 : cursor_row;
  assign exc_raw   = row_a - ROW_W'(rows) + ROW_W'(1);

  // end-of-byte advance
  assign gpr1       = {1'b0, glyph_pixel_row} + (GPR_W+1)'(1);
  assign gbc1       = {1'b0, glyph_byte_column} + (GBC_W+1)'(1);
  assign bpr_sum    = {1'b0, cw} + (CW_W+1)'(7);
  assign bpr        = bpr_sum[CW_W:3];
  assign next_col   = {1'b0, cursor_column} + (COL_W+1)'(1);
  assign wrap_diff  = next_col - (COL_W+1)'(cols);
  assign row_done   = gpr1 >= ch;
  assign glyph_done = row_done && ((CW_W-2)'(gbc1) >= bpr);
  assign col_wrap   = next_col >= (COL_W+1)'(cols);
  assign need_div   = glyph_done && col_wrap && (wrap_diff >= (COL_W+1)'(cols));

  assign row_sum = {2'b00, cursor_row} + (ROW_W+2)'(div_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column     <= '0;
      cursor_row        <= '0;
      glyph_byte_column <= '0;
      glyph_pixel_row   <= '0;
    end else begin
      if (cmd.load) begin
        if (item.kind == KIND_CR || item.kind == KIND_LF) begin
          cursor_column     <= '0;
          glyph_byte_column <= '0;
          glyph_pixel_row   <= '0;
          if (item.kind == KIND_LF) begin
            cursor_row <= row_inc1;
          end
        end
      end
      if (cmd.check && chk_start && (col_over || cursor_row >= ROW_W'(rows))) begin
        cursor_column <= '0;
        if (row_a >= ROW_W'(rows)) begin
          cursor_row <= ROW_W'(rows) - ROW_W'(1);
        end else begin
          cursor_row <= row_a;
        end
      end
      if (cmd.advance) begin
        if (!row_done) begin
          glyph_pixel_row <= gpr1[GPR_W-1:0];
        end else begin
          glyph_pixel_row <= '0;
          if (!glyph_done) begin
            glyph_byte_column <= gbc1[GBC_W-1:0];
          end else begin
            glyph_byte_column <= '0;
            if (!col_wrap) begin
              cursor_column <= next_col[COL_W-1:0];
            end else if (!need_div) begin
              cursor_row    <= row_inc1;
              cursor_column <= wrap_diff[COL_W-1:0];
            end
          end
        end
      end
      if (cmd.div_finish) begin
        cursor_row    <= (row_sum > (ROW_W+2)'(ROW_LIMIT)) ? ROW_W'(ROW_LIMIT) :
                         row_sum[ROW_W-1:0];
        cursor_column <= div_r;
      end
    end
  end

  tcgr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.advance && need_div),
    .dividend  (next_col),
    .divisor   (cols),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // emit mask: byte pixel in glyph width, inside text area, and set or opaque
  always_comb begin
    logic [CW_W-1:0] pos;
    logic [X_W-1:0]  xk;
    mask_next = '0;
    for (int k = 0; k < PIX_N; k++) begin
      pos = CW_W'({glyph_byte_column, 3'b000}) + CW_W'(k);
      xk  = xbase + X_W'(k);
      mask_next[k] = (pos < cw) && (xk < area_w) && (ybase < area_h) &&
                     (bits[3'(PIX_N - 1 - k)] || !transparent_background);
    end
  end

  always_comb begin
    sel_k = '0;
    for (int k = PIX_N - 1; k >= 0; k--) begin
      if (mask[k]) begin
        sel_k = 3'(k);
      end
    end
  end

  assign mask_cleared = mask & ~(PIX_N'(1) << sel_k);
  assign pix_last     = (mask_cleared == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bits <= item.glyph_byte;
    end
    if (cmd.check) begin
      scroll_pend <= 1'b0;
      if (chk_start && (col_over || cursor_row >= ROW_W'(rows)) &&
          row_a >= ROW_W'(rows)) begin
        scroll_pend <= 1'b1;
        excess      <= (exc_raw > ROW_W'(rows)) ? ROW_W'(rows) : exc_raw;
      end
    end
    if (cmd.mul1) begin
      xbase  <= X_W'(cursor_column) * X_W'(cw) + X_W'({glyph_byte_column, 3'b000});
      ybase  <= Y_W'(cursor_row) * Y_W'(ch) + Y_W'(glyph_pixel_row);
      area_w <= X_W'(cols) * X_W'(cw);
      area_h <= Y_W'(rows) * Y_W'(ch);
      lines  <= LINES_W'(excess) * LINES_W'(ch);
    end
    if (cmd.mul2) begin
      yoff <= YOFF_W'(ybase) * YOFF_W'(pitch);
      mask <= mask_next;
    end
    if (cmd.emit_pixel) begin
      mask <= mask_cleared;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_scroll || cmd.emit_pixel) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_scroll) begin
      result.result_kind   <= RK_SCROLL;
      result.pixel_address <= '0;
      result.pixel_color   <= '0;
      result.scroll_lines  <= lines;
      result.last          <= (mask == '0);
    end else if (cmd.emit_pixel) begin
      result.result_kind   <= RK_PIXEL;
      result.pixel_address <= ADDR_W'(yoff + YOFF_W'(xbase) + YOFF_W'(sel_k));
      result.pixel_color   <= bits[3'(PIX_N - 1) - sel_k] ? text_color : background_color;
      result.scroll_lines  <= '0;
      result.last          <= pix_last;
    end
  end

  assign status.item_glyph  = (item.kind == KIND_GLYPH);
  assign status.scroll_pend = scroll_pend;
  assign status.any_pixel   = (mask != '0);
  assign status.pix_last    = pix_last;
  assign status.out_free    = !result_valid || result_ready;
  assign status.need_div    = need_div;
  assign status.div_done    = div_done;

endmodule

[design/tcgr_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console glyph renderer controller
// Sequences load, scroll check, multiply, emit, cursor advance and column divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcgr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tcgr_pkg::dp_status_t status,
  output tcgr_pkg::dp_cmd_t    cmd
);
  import tcgr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_MUL1   = 8'b0000_0100,
    S_MUL2   = 8'b0000_1000,
    S_SCROLL = 8'b0001_0000,
    S_EMIT   = 8'b0010_0000,
    S_ADV    = 8'b0100_0000,
    S_DIV    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          if (status.item_glyph) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = status.scroll_pend ? S_SCROLL : S_EMIT;
      end
      S_SCROLL: begin
        if (status.out_free) begin
          cmd.emit_scroll = 1'b1;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.any_pixel) begin
          state_next = S_ADV;
        end else if (status.out_free) begin
          cmd.emit_pixel = 1'b1;
          if (status.pix_last) begin
            state_next = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = status.need_div ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.div_finish = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[design/tcgr_checker.sv]
// ----------------------------------------------------------------------------
// Text console glyph renderer port checker
// Port-level properties of the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_glyph_renderer_defines.svh"

module tcgr_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input tcgr_pkg::item_t     item,
  input logic                result_valid,
  input logic                result_ready,
  input tcgr_pkg::result_t   result
);
  import tcgr_pkg::*;

  `TCGR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
  `TCGR_ASSERT_NEXT(a_glyph_busy, item_valid && item_ready && item.kind == KIND_GLYPH, !item_ready)
  `TCGR_ASSERT_IMPL(a_scroll_fields, result_valid && result.result_kind == RK_SCROLL, result.pixel_address == '0 && result.pixel_color == '0 && result.scroll_lines != '0)
  `TCGR_ASSERT_IMPL(a_pixel_fields, result_valid && result.result_kind == RK_PIXEL, result.scroll_lines == '0)

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);

[sim/text_console_glyph_renderer_tb.sv]
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Drives glyph bytes, carriage returns and line feeds through the item channel
// under bursty traffic and a stalling result consumer. A cursor and glyph
// position tracker in the bench computes every pixel write and scroll request,
// and each result transaction is matched field by field in order. Register
// settings change between phases, from the smallest to the largest sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_glyph_renderer_tb;
  import tcgr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 210;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;

  text_console_glyph_renderer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic [CW_W-1:0] glyph_w;
  logic [CH_W-1:0] glyph_h;
  logic [COLS_W-1:0] cols_reg;
  logic [ROWS_W-1:0] rows_reg;
  logic [PITCH_W-1:0] pitch_reg;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic transparent;

  // cursor and glyph position
  int unsigned cur_col, cur_row, byte_col, pix_row;

  result_t framebuffer_ops[$];
  result_t want;
  int errors = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned bump_row(int unsigned r, int unsigned by);
    return (r + by > ROW_LIMIT) ? ROW_LIMIT : r + by;
  endfunction

  function automatic void draw_item(item_t it);
    int unsigned cw, ch, cols, rows, excess, nxt, bpr, lines;
    longint unsigned pitch, area_w, area_h, x0, x, y, addr;
    logic [COLOR_W-1:0] color;
    result_t r, held;
    logic have_held;
    have_held = 1'b0;
    held = '0;
    if (it.kind == KIND_CR || it.kind == KIND_LF) begin
      cur_col = 0;
      if (it.kind == KIND_LF) cur_row = bump_row(cur_row, 1);
      byte_col = 0;
      pix_row = 0;
      return;
    end
    if (it.kind != KIND_GLYPH) return;
    cw = saturate(glyph_w, 1, MAX_CHAR_WIDTH);
    ch = saturate(glyph_h, 1, MAX_CHAR_HEIGHT);
    cols = saturate(cols_reg, 1, MAX_TEXT_COLUMNS);
    rows = saturate(rows_reg, 1, MAX_TEXT_ROWS);
    pitch = saturate(pitch_reg, 1, MAX_LINE_PITCH);
    area_w = longint'(cols) * cw;
    area_h = longint'(rows) * ch;

    if (byte_col == 0 && pix_row == 0 && (cur_col >= cols || cur_row >= rows)) begin
      if (cur_col >= cols) cur_row = bump_row(cur_row, 1);
      cur_col = 0;
      if (cur_row >= rows) begin
        excess = cur_row - rows + 1;
        if (excess > rows) excess = rows;
        cur_row = rows - 1;
        lines = excess * ch;
        held = '0;
        held.result_kind = RK_SCROLL;
        held.scroll_lines = lines[LINES_W-1:0];
        have_held = 1'b1;
      end
    end

    x0 = longint'(cur_col) * cw + longint'(byte_col) * 8;
    y = longint'(cur_row) * ch + pix_row;
    for (int k = 0; k < 8; k++) begin
      if (byte_col * 8 + k >= cw) break;
      x = x0 + k;
      if (x >= area_w || y >= area_h) break;
      if (it.glyph_byte[7-k]) color = fg_color;
      else if (transparent) continue;
      else color = bg_color;
      addr = x + y * pitch;
      r = '0;
      r.result_kind = RK_PIXEL;
      r.pixel_address = addr[ADDR_W-1:0];
      r.pixel_color = color;
      if (have_held) framebuffer_ops.push_back(held);
      held = r;
      have_held = 1'b1;
    end

    pix_row++;
    if (pix_row >= ch) begin
      pix_row = 0;
      byte_col++;
      bpr = (cw + 7) >> 3;
      if (byte_col >= bpr) begin
        byte_col = 0;
        nxt = cur_col + 1;
        if (nxt >= cols) begin
          cur_row = bump_row(cur_row, nxt / cols);
          nxt = nxt % cols;
        end
        cur_col = nxt;
      end
    end

    if (have_held) begin
      held.last = 1'b1;
      framebuffer_ops.push_back(held);
    end
  endfunction

  function automatic void compare_field(string name, longint unsigned exp, longint unsigned act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      errors++;
    end
  endfunction

  // result transactions
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (framebuffer_ops.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        errors++;
      end else begin
        want = framebuffer_ops.pop_front();
        compare_field("result_kind", want.result_kind, result.result_kind);
        compare_field("pixel_address", want.pixel_address, result.pixel_address);
        compare_field("pixel_color", want.pixel_color, result.pixel_color);
        compare_field("scroll_lines", want.scroll_lines, result.scroll_lines);
        compare_field("last", want.last, result.last);
      end
    end
  end

  // consumer stall pattern, in randomly picked modes
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_tick = 0;
    end else begin
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      stall_tick++;
      case (stall_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= $urandom_range(0, 1);
        2: result_ready <= (stall_tick % 4 == 0);
        default: result_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] bits);
    item_t it;
    it.kind = kind;
    it.glyph_byte = bits;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    draw_item(it);
    burst_left--;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    while (framebuffer_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_CHAR_WIDTH:   glyph_w = value[CW_W-1:0];
      CFG_CHAR_HEIGHT:  glyph_h = value[CH_W-1:0];
      CFG_TEXT_COLUMNS: cols_reg = value[COLS_W-1:0];
      CFG_TEXT_ROWS:    rows_reg = value[ROWS_W-1:0];
      CFG_LINE_PITCH:   pitch_reg = value[PITCH_W-1:0];
      CFG_TEXT_COLOR:   fg_color = value[COLOR_W-1:0];
      CFG_BG_COLOR:     bg_color = value[COLOR_W-1:0];
      CFG_TRANSPARENT:  transparent = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int unsigned cw, ch, cols, rows, pitch, fg, bg, tr);
    write_reg(CFG_CHAR_WIDTH, cw);
    write_reg(CFG_CHAR_HEIGHT, ch);
    write_reg(CFG_TEXT_COLUMNS, cols);
    write_reg(CFG_TEXT_ROWS, rows);
    write_reg(CFG_LINE_PITCH, pitch);
    write_reg(CFG_TEXT_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
    write_reg(CFG_TRANSPARENT, tr);
  endtask

  // random upper bits beyond the register width now and then
  function automatic int unsigned with_junk(int unsigned v, int unsigned w);
    if ($urandom_range(0, 3) != 0) return v;
    return (v & ((32'd1 << w) - 1)) | ($urandom() << w);
  endfunction

  task automatic test_reset_defaults();
    send_item(KIND_GLYPH, 8'hFF);
    send_item(KIND_GLYPH, 8'h00);
    send_item(KIND_GLYPH, 8'hA5);
    send_item(KIND_CR, 8'hFF);
    send_item(KIND_LF, 8'h00);
    send_item(KIND_UNUSED, 8'hFF);
    send_item(KIND_GLYPH, 8'h3C);
    settle();
  endtask

  // zero registers clamp to the low bounds
  task automatic test_minimum_sizes();
    apply_setup(0, 0, 0, 0, 0, 0, 24'hFFFFFF, 1);
    send_item(KIND_GLYPH, 8'h80);
    send_item(KIND_GLYPH, 8'h7F);
    send_item(KIND_GLYPH, 8'hFF);
    settle();
  endtask

  task automatic test_maximum_sizes();
    apply_setup(63, 127, 1023, 511, 16383, 24'hFFFFFF, 24'h123456, 0);
    apply_setup(63, 1, 1023, 511, 16383, 24'hFFFFFF, 24'h123456, 0);
    send_item(KIND_GLYPH, 8'hFF);
    send_item(KIND_GLYPH, 8'h0F);
    send_item(KIND_GLYPH, 8'hF0);
    send_item(KIND_GLYPH, 8'h01);
    send_item(KIND_UNUSED, 8'h00);
    send_item(KIND_GLYPH, 8'hC3);
    settle();
  endtask

  // shrink the text area in the middle of a glyph
  task automatic test_clip_and_column_wrap();
    apply_setup(1, 2, 1023, 2, 100, 24'h00FF00, 24'h0000FF, 0);
    send_item(KIND_CR, 8'h00);
    repeat (9) send_item(KIND_GLYPH, $urandom_range(0, 255));
    settle();
    apply_setup(1, 2, 2, 2, 100, 24'h00FF00, 24'h0000FF, 0);
    send_item(KIND_GLYPH, 8'hFF);
    send_item(KIND_GLYPH, 8'h80);
    send_item(KIND_GLYPH, 8'h00);
    send_item(KIND_GLYPH, 8'hFF);
    settle();
    apply_setup(1, 2, 2, 1, 100, 24'h00FF00, 24'h0000FF, 0);
    send_item(KIND_GLYPH, 8'hFF);
    send_item(KIND_GLYPH, 8'hFF);
    settle();
  endtask

  // far past the last row, scroll capped at the text area height, then a short one
  task automatic test_scroll_capping();
    apply_setup(8, 64, 80, 4, 8192, 24'hABCDEF, 24'h010203, 0);
    send_item(KIND_CR, 8'h00);
    repeat (20) send_item(KIND_LF, $urandom_range(0, 255));
    send_item(KIND_GLYPH, 8'hC3);
    repeat (2) send_item(KIND_LF, $urandom_range(0, 255));
    send_item(KIND_GLYPH, 8'h5A);
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned sent, count, pick;
    logic [7:0] bits;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_setup(
        with_junk(($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 63),
                  CW_W),
        with_junk(($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(0, 127),
                  CH_W),
        with_junk(($urandom_range(0, 2) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 1023),
                  COLS_W),
        with_junk(($urandom_range(0, 2) != 0) ? $urandom_range(1, 3) : $urandom_range(0, 511),
                  ROWS_W),
        with_junk(($urandom_range(0, 1) != 0) ? $urandom_range(1, 300) : $urandom_range(0, 16383),
                  PITCH_W),
        $urandom(), $urandom(), with_junk($urandom_range(0, 1), 1));
      count = $urandom_range(8, 40);
      repeat (count) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 6))
          0: bits = 8'h00;
          1: bits = 8'hFF;
          default: bits = $urandom_range(0, 255);
        endcase
        if (pick < 4) send_item(KIND_CR, bits);
        else if (pick < 8) send_item(KIND_LF, bits);
        else if (pick < 10) send_item(KIND_UNUSED, bits);
        else send_item(KIND_GLYPH, bits);
      end
      sent += count;
      settle();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    glyph_w = 8;
    glyph_h = 16;
    cols_reg = 80;
    rows_reg = 25;
    pitch_reg = 1024;
    fg_color = 24'hCCCCCC;
    bg_color = '0;
    transparent = 1'b0;
    cur_col = 0;
    cur_row = 0;
    byte_col = 0;
    pix_row = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_minimum_sizes();
    test_maximum_sizes();
    test_clip_and_column_wrap();
    test_scroll_capping();
    test_random_traffic();

    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
